### hw/rtl/newest_first_topk_insert_list_unit_assert.svh
// Assertion macros for the checker of the insertion list unit.
`ifndef NEWEST_FIRST_TOPK_INSERT_LIST_UNIT_ASSERT_SVH
`define NEWEST_FIRST_TOPK_INSERT_LIST_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define NFTK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("insertion list assertion failed");

// Clocked assertion that holds during reset as well.
`define NFTK_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("insertion list assertion failed");

`endif

### hw/rtl/nftk_pkg.sv
// Package with the types and constants of the insertion list unit.
package nftk_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W = 32;
	localparam int SIZE_W = 32;
	localparam int TAG_W = 16;
	localparam int RIDX_W = 4;
	localparam int COUNT_W = 5;
	localparam int POS_W = 4;
	localparam int RD_SPAN = 16;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_INSERT = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SIZE_W-1:0] size;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [KEY_W-1:0] stamp_key;
		logic [SIZE_W-1:0] entry_size;
		logic [TAG_W-1:0] name_tag;
		logic [RIDX_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] entry_count;
		logic was_inserted;
		logic [POS_W-1:0] insert_position;
		logic read_valid;
		logic [KEY_W-1:0] read_key;
		logic [SIZE_W-1:0] read_size;
		logic [TAG_W-1:0] read_tag;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic insert;
	} cell_cmd_t;

	typedef struct packed {
		logic valid;
		logic greater;
		entry_t entry;
	} cell_link_t;

	typedef struct packed {
		logic placed;
		logic [POS_W-1:0] position;
		logic rd_valid;
		entry_t rd_entry;
	} chain_stat_t;

endpackage

### hw/rtl/nftk_stream_if.sv
// Valid/ready channel interface that carries one item per handshake.
interface nftk_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/nftk_cell.sv
// One list cell: holds an entry, compares it to the new key and shifts or loads.
module nftk_cell (
	input logic clk,
	input logic arst_n,
	input nftk_pkg::cell_cmd_t cmd,
	input nftk_pkg::entry_t new_entry,
	input nftk_pkg::cell_link_t prev,
	output nftk_pkg::cell_link_t link,
	output logic landing
);

	logic valid_q;
	nftk_pkg::entry_t entry_q;
	logic greater;

	assign greater = valid_q && (entry_q.key > new_entry.key);
	assign landing = !greater && prev.greater;

	assign link.valid = valid_q;
	assign link.greater = greater;
	assign link.entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.insert && !greater) begin
			valid_q <= prev.greater | prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !greater) begin
			if (prev.greater) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= prev.entry;
			end
		end
	end

endmodule

### hw/rtl/nftk_chain.sv
// Row of list cells with the landing position encoder and the read selection.
module nftk_chain #(
	parameter int DEPTH = nftk_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input nftk_pkg::cell_cmd_t cmd,
	input nftk_pkg::entry_t new_entry,
	input logic [nftk_pkg::RIDX_W-1:0] read_index,
	output nftk_pkg::chain_stat_t stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int RD_N = (DEPTH < nftk_pkg::RD_SPAN) ? DEPTH : nftk_pkg::RD_SPAN;

	nftk_pkg::cell_link_t links [DEPTH+1];
	logic [DEPTH-1:0] landing;
	logic [PW-1:0] pos;
	logic [PW+nftk_pkg::POS_W-1:0] pos_ext;

	assign links[0] = '{valid: 1'b0, greater: 1'b1, entry: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		nftk_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.new_entry(new_entry),
			.prev(links[i]),
			.link(links[i+1]),
			.landing(landing[i])
		);
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (landing[i]) begin
				pos = pos | PW'(i);
			end
		end
	end

	assign pos_ext = {{nftk_pkg::POS_W{1'b0}}, pos};

	always_comb begin
		stat.placed = !links[DEPTH].greater;
		stat.position = pos_ext[nftk_pkg::POS_W-1:0];
		stat.rd_valid = 1'b0;
		stat.rd_entry = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (read_index == nftk_pkg::RIDX_W'(i)) begin
				stat.rd_valid = links[i+1].valid;
				stat.rd_entry = links[i+1].entry;
			end
		end
	end

endmodule

### hw/rtl/newest_first_topk_insert_list_unit.sv
// Top level of the newest-first sorted insertion list with its result register.
//
//   channel   dir   item type    contents
//   request   in    in_item_t    operation, stamp_key, entry_size, name_tag, read_index
//   result    out   out_item_t   entry_count, insert status, read entry
//
// Each item is handled in the cell row; its result is registered and appears in the cycle after it is taken.
// A new item is taken in every cycle while the result register is free or drains.
// The result register alone sets the rate: a stalled result holds back the request.
// Reset empties the list and the result register at once; no clearing pass.
module newest_first_topk_insert_list_unit #(
	parameter int DEPTH = nftk_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	nftk_stream_if.sink request,
	nftk_stream_if.source result
);

	localparam int CW = $clog2(DEPTH + 1);

	logic accept;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [CW+nftk_pkg::COUNT_W-1:0] count_ext;
	logic out_valid_q;
	nftk_pkg::out_item_t out_q;
	nftk_pkg::out_item_t out_next;
	nftk_pkg::cell_cmd_t cmd;
	nftk_pkg::entry_t new_entry;
	nftk_pkg::chain_stat_t stat;
	nftk_pkg::in_item_t req;

	assign req = request.data;
	assign request.ready = !out_valid_q || result.ready;
	assign accept = request.valid && request.ready;

	assign cmd.clear = accept && (req.operation == nftk_pkg::OP_CLEAR);
	assign cmd.insert = accept && (req.operation == nftk_pkg::OP_INSERT);

	assign new_entry = '{key: req.stamp_key, size: req.entry_size, tag: req.name_tag};

	nftk_chain #(
		.DEPTH(DEPTH)
	) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.new_entry(new_entry),
		.read_index(req.read_index),
		.stat(stat)
	);

	always_comb begin
		count_next = count_q;
		case (req.operation)
			nftk_pkg::OP_CLEAR: begin
				count_next = '0;
			end
			nftk_pkg::OP_INSERT: begin
				if (stat.placed && (count_q != CW'(DEPTH))) begin
					count_next = count_q + CW'(1);
				end
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	assign count_ext = {{nftk_pkg::COUNT_W{1'b0}}, count_next};

	always_comb begin
		out_next = '0;
		out_next.entry_count = count_ext[nftk_pkg::COUNT_W-1:0];
		case (req.operation)
			nftk_pkg::OP_INSERT: begin
				if (stat.placed) begin
					out_next.was_inserted = 1'b1;
					out_next.insert_position = stat.position;
				end
			end
			nftk_pkg::OP_READ: begin
				if (stat.rd_valid) begin
					out_next.read_valid = 1'b1;
					out_next.read_key = stat.rd_entry.key;
					out_next.read_size = stat.rd_entry.size;
					out_next.read_tag = stat.rd_entry.tag;
				end
			end
			default: begin
				out_next.was_inserted = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= out_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

endmodule

### hw/rtl/nftk_checker.sv
// Port checker for the insertion list unit and the bind that attaches it.
`include "newest_first_topk_insert_list_unit_assert.svh"

module nftk_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] in_op,
	input logic out_valid,
	input logic out_ready,
	input logic [nftk_pkg::COUNT_W-1:0] out_count,
	input logic out_inserted,
	input logic out_rvalid
);

	logic in_acc;
	logic clr_acc;
	logic out_empty;

	assign in_acc = in_valid && in_ready;
	assign clr_acc = in_acc && (in_op == nftk_pkg::OP_CLEAR);
	assign out_empty = (out_count == '0) && !out_inserted && !out_rvalid;

	`NFTK_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`NFTK_ASSERT(a_clear_empties, clk, arst_n, clr_acc |=> out_valid && out_empty)
	`NFTK_ASSERT(a_stall_only_on_full, clk, arst_n, !in_ready |-> out_valid && !out_ready)
	`NFTK_ASSERT(a_one_kind, clk, arst_n, !(out_valid && out_inserted && out_rvalid))

endmodule

bind newest_first_topk_insert_list_unit nftk_checker u_nftk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(request.valid),
	.in_ready(request.ready),
	.in_op(request.data.operation),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_count(result.data.entry_count),
	.out_inserted(result.data.was_inserted),
	.out_rvalid(result.data.read_valid)
);
